@@ rtl/bitplane_image_rle_depacker_defines.svh @@
// assertion macros for the bit-plane image run-length depacker
// used by the top level only
`ifndef BITPLANE_IMAGE_RLE_DEPACKER_DEFINES_SVH
`define BITPLANE_IMAGE_RLE_DEPACKER_DEFINES_SVH

// check a condition at every rising clock edge outside reset
`define BIRD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check that one condition implies another in the next cycle
`define BIRD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/bird_pkg.sv @@
// shared types and constants for the bit-plane image depacker
// no dependencies
package bird_pkg;

   localparam int MAX_LINE_BYTES    = 2048;
   localparam int MAX_PATTERN_BYTES = 16;
   localparam int MAX_PLANES        = 8;

   localparam logic [2:0] PH_OPCODE     = 3'd0;
   localparam logic [2:0] PH_PAT_COUNT  = 3'd1;
   localparam logic [2:0] PH_PAT_BYTES  = 3'd2;
   localparam logic [2:0] PH_SCAN_MARK  = 3'd3;
   localparam logic [2:0] PH_SCAN_COUNT = 3'd4;
   localparam logic [2:0] PH_LIT_COUNT  = 3'd5;
   localparam logic [2:0] PH_LIT_BYTES  = 3'd6;

   localparam logic [1:0] KIND_SOLID   = 2'd0;
   localparam logic [1:0] KIND_LITERAL = 2'd1;
   localparam logic [1:0] KIND_PATTERN = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_BAD_MARK = 2'd1;
   localparam logic [1:0] ERR_OVERRUN  = 2'd2;

   localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
   localparam logic [1:0] REG_HEIGHT     = 2'd1;
   localparam logic [1:0] REG_PLANES     = 2'd2;
   localparam logic [1:0] REG_PATTERN    = 2'd3;

   localparam logic [7:0] OP_LITERAL   = 8'h80;
   localparam logic [7:0] RUN_MASK     = 8'h7F;
   localparam logic [7:0] SCAN_MARKER  = 8'hFF;

   // one classified write, front to back
   typedef struct packed {
      logic [1:0]   kind;
      logic [11:0]  run_length;
      logic [63:0]  data_low;
      logic [63:0]  data_high;
      logic [1:0]   error_code;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  plane_index;
      logic [14:0] line_index;
      logic [10:0] column;
      logic [11:0] run_length;
      logic [63:0] data_low;
      logic [63:0] data_high;
      logic        line_done;
      logic [7:0]  line_repeat;
      logic        image_done;
      logic [1:0]  error_code;
   } rsp_type;

   typedef struct packed {
      logic [11:0] width;
      logic [14:0] height;
      logic [3:0]  planes;
      logic [4:0]  pattern;
   } cfg_type;

endpackage

@@ rtl/bird_fifo.sv @@
// two-entry queue of classified writes between front and back
// depends on bird_pkg
module bird_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bird_pkg::cmd_type push_data,
   output logic              full,
   output logic              empty,
   input  logic              pop,
   output bird_pkg::cmd_type pop_data
);
   bird_pkg::cmd_type mem_ff [2];
   logic              wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]        cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule

@@ rtl/bird_front.sv @@
// front part: byte parser, pattern store, column and overrun check
// depends on bird_pkg
module bird_front (
   input  logic              clock,
   input  logic              reset,
   input  bird_pkg::cfg_type cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        in_byte,
   output logic              push,
   output bird_pkg::cmd_type push_data,
   input  logic              full,
   input  logic              back_done,
   output logic              halted
);
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  pat_ff [16];
   logic [4:0]  fill_ff, fill_in;
   logic [7:0]  pcount_ff, pcount_in;
   logic [7:0]  lit_ff, lit_in;
   logic [11:0] col_ff, col_in;
   logic        halt_ff, halt_in;
   logic [11:0] width;
   logic [4:0]  plen;
   logic [12:0] col_end;
   logic [11:0] pat_run;
   logic [13:0] pat_end;
   logic        take;
   logic [127:0] pat_bits;

   assign width = (cfg.width == 12'd0) ? 12'd1 :
                  (cfg.width > 12'(bird_pkg::MAX_LINE_BYTES)) ?
                  12'(bird_pkg::MAX_LINE_BYTES) : cfg.width;
   assign plen  = (cfg.pattern > 5'(bird_pkg::MAX_PATTERN_BYTES)) ?
                  5'(bird_pkg::MAX_PATTERN_BYTES) : cfg.pattern;
   assign in_ready = !full;
   assign take     = in_valid && !full;
   assign halted   = halt_ff;
   assign pat_run  = 12'(pcount_ff * plen);
   assign pat_end  = {2'b00, col_ff} + 14'(in_byte * plen);

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         pat_bits[i*8 +: 8] = (5'(i) < plen) ?
            ((5'(i) == fill_ff) ? in_byte : pat_ff[i]) : 8'h00;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      fill_in   = fill_ff;
      pcount_in = pcount_ff;
      lit_in    = lit_ff;
      col_in    = col_ff;
      halt_in   = halt_ff | back_done;
      push      = 1'b0;
      push_data = '0;
      col_end   = 13'd0;
      if (take && !halt_ff) begin
         case (phase_ff)
            bird_pkg::PH_OPCODE: begin
               if (in_byte == 8'h00) begin
                  phase_in = bird_pkg::PH_PAT_COUNT;
               end else if (in_byte == bird_pkg::OP_LITERAL) begin
                  phase_in = bird_pkg::PH_LIT_COUNT;
               end else begin
                  push = 1'b1;
                  push_data.kind = bird_pkg::KIND_SOLID;
                  push_data.run_length = {5'd0, in_byte[6:0]};
                  push_data.data_low = in_byte[7] ? 64'hFF : 64'h0;
                  col_end = {1'b0, col_ff} + {6'd0, in_byte[6:0]};
               end
            end
            bird_pkg::PH_PAT_COUNT: begin
               if (in_byte == 8'h00) begin
                  phase_in = bird_pkg::PH_SCAN_MARK;
               end else if (plen == 5'd0) begin
                  phase_in = bird_pkg::PH_OPCODE;
               end else if (pat_end > {2'b00, width}) begin
                  push = 1'b1;
                  push_data.kind = bird_pkg::KIND_ERROR;
                  push_data.error_code = bird_pkg::ERR_OVERRUN;
                  halt_in  = 1'b1;
                  phase_in = bird_pkg::PH_OPCODE;
               end else begin
                  pcount_in = in_byte;
                  fill_in   = 5'd0;
                  phase_in  = bird_pkg::PH_PAT_BYTES;
               end
            end
            bird_pkg::PH_PAT_BYTES: begin
               fill_in = fill_ff + 5'd1;
               if (fill_in >= plen) begin
                  fill_in  = 5'd0;
                  phase_in = bird_pkg::PH_OPCODE;
                  push = 1'b1;
                  push_data.kind = bird_pkg::KIND_PATTERN;
                  push_data.run_length = pat_run;
                  push_data.data_low  = pat_bits[63:0];
                  push_data.data_high = pat_bits[127:64];
                  col_end = {1'b0, col_ff} + {1'b0, pat_run};
               end
            end
            bird_pkg::PH_SCAN_MARK: begin
               if (in_byte != bird_pkg::SCAN_MARKER) begin
                  push = 1'b1;
                  push_data.kind = bird_pkg::KIND_ERROR;
                  push_data.error_code = bird_pkg::ERR_BAD_MARK;
                  halt_in  = 1'b1;
                  phase_in = bird_pkg::PH_OPCODE;
               end else begin
                  phase_in = bird_pkg::PH_SCAN_COUNT;
               end
            end
            bird_pkg::PH_SCAN_COUNT: begin
               push = 1'b1;
               push_data.kind = bird_pkg::KIND_SOLID;
               push_data.error_code = bird_pkg::ERR_BAD_MARK;
               push_data.data_high = {56'd0, (in_byte == 8'h00) ? 8'd1 : in_byte};
               phase_in = bird_pkg::PH_OPCODE;
            end
            bird_pkg::PH_LIT_COUNT: begin
               if (in_byte == 8'h00) begin
                  phase_in = bird_pkg::PH_OPCODE;
               end else if ({1'b0, col_ff} + {5'd0, in_byte} > {1'b0, width}) begin
                  push = 1'b1;
                  push_data.kind = bird_pkg::KIND_ERROR;
                  push_data.error_code = bird_pkg::ERR_OVERRUN;
                  halt_in  = 1'b1;
                  phase_in = bird_pkg::PH_OPCODE;
               end else begin
                  lit_in   = in_byte;
                  phase_in = bird_pkg::PH_LIT_BYTES;
               end
            end
            bird_pkg::PH_LIT_BYTES: begin
               if (lit_ff <= 8'd1) begin
                  lit_in   = 8'd0;
                  phase_in = bird_pkg::PH_OPCODE;
               end else begin
                  lit_in = lit_ff - 8'd1;
               end
               push = 1'b1;
               push_data.kind = bird_pkg::KIND_LITERAL;
               push_data.run_length = 12'd1;
               push_data.data_low = {56'd0, in_byte};
               col_end = {1'b0, col_ff} + 13'd1;
            end
            default: begin
               phase_in = bird_pkg::PH_OPCODE;
            end
         endcase
         // write descriptors: track column, flag overrun
         if (push && push_data.kind != bird_pkg::KIND_ERROR &&
             !(phase_ff == bird_pkg::PH_SCAN_COUNT)) begin
            if (col_end > {1'b0, width}) begin
               push_data = '0;
               push_data.kind = bird_pkg::KIND_ERROR;
               push_data.error_code = bird_pkg::ERR_OVERRUN;
               halt_in  = 1'b1;
               phase_in = bird_pkg::PH_OPCODE;
            end else if (col_end == {1'b0, width}) begin
               col_in = 12'd0;
            end else begin
               col_in = col_end[11:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= bird_pkg::PH_OPCODE;
         fill_ff   <= 5'd0;
         pcount_ff <= 8'd0;
         lit_ff    <= 8'd0;
         col_ff    <= 12'd0;
         halt_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         fill_ff   <= fill_in;
         pcount_ff <= pcount_in;
         lit_ff    <= lit_in;
         col_ff    <= col_in;
         halt_ff   <= halt_in;
      end
      if (take && !halt_ff && phase_ff == bird_pkg::PH_PAT_BYTES) begin
         pat_ff[fill_ff[3:0]] <= in_byte;
      end
   end
endmodule

@@ rtl/bird_back.sv @@
// back part: plane and line tracking, descriptor completion, output register
// depends on bird_pkg
module bird_back (
   input  logic              clock,
   input  logic              reset,
   input  bird_pkg::cfg_type cfg,
   input  logic              empty,
   output logic              pop,
   input  bird_pkg::cmd_type pop_data,
   output logic              out_valid,
   input  logic              out_ready,
   output bird_pkg::rsp_type out_data,
   output logic              done
);
   logic [10:0] col_ff, col_in;
   logic [2:0]  plane_ff, plane_in;
   logic [14:0] line_ff, line_in;
   logic [7:0]  rep_ff, rep_in;
   logic        valid_ff, valid_in;
   bird_pkg::rsp_type data_ff, data_in;
   logic        done_ff, done_in;
   logic [11:0] width;
   logic [14:0] height;
   logic [3:0]  planes;
   logic [12:0] col_end;
   logic [14:0] remain;
   logic [7:0]  rep_out;
   logic [15:0] line_end;
   logic        is_scan;

   assign width  = (cfg.width == 12'd0) ? 12'd1 :
                   (cfg.width > 12'(bird_pkg::MAX_LINE_BYTES)) ?
                   12'(bird_pkg::MAX_LINE_BYTES) : cfg.width;
   assign height = (cfg.height == 15'd0) ? 15'd1 : cfg.height;
   assign planes = (cfg.planes == 4'd0) ? 4'd1 :
                   (cfg.planes > 4'(bird_pkg::MAX_PLANES)) ?
                   4'(bird_pkg::MAX_PLANES) : cfg.planes;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign done      = done_ff;
   // once halted, queued writes are drained and dropped
   assign pop       = !empty && (done_ff || !valid_ff || out_ready);
   // scan repeat travels as a solid kind carrying the bad-mark code
   assign is_scan   = pop_data.kind == bird_pkg::KIND_SOLID &&
                      pop_data.error_code == bird_pkg::ERR_BAD_MARK;
   assign col_end   = {2'b00, col_ff} + {1'b0, pop_data.run_length};
   assign remain    = (line_ff < height) ? (height - line_ff) : 15'd1;
   assign rep_out   = ({7'd0, rep_ff} < remain) ? rep_ff : remain[7:0];
   assign line_end  = {1'b0, line_ff} + {8'd0, rep_out};

   always_comb begin
      col_in   = col_ff;
      plane_in = plane_ff;
      line_in  = line_ff;
      rep_in   = rep_ff;
      done_in  = done_ff;
      valid_in = valid_ff && !out_ready;
      data_in  = data_ff;
      if (pop && !done_ff) begin
         if (is_scan) begin
            rep_in = pop_data.data_high[7:0];
         end else begin
            valid_in = 1'b1;
            data_in = '0;
            data_in.kind        = pop_data.kind;
            data_in.plane_index = plane_ff;
            data_in.line_index  = line_ff;
            data_in.column      = col_ff;
            data_in.run_length  = pop_data.run_length;
            data_in.data_low    = pop_data.data_low;
            data_in.data_high   = pop_data.data_high;
            data_in.error_code  = pop_data.error_code;
            if (pop_data.kind == bird_pkg::KIND_ERROR) begin
               done_in = 1'b1;
            end else if (col_end == {1'b0, width}) begin
               data_in.line_done   = 1'b1;
               data_in.line_repeat = rep_out;
               data_in.image_done  = ({1'b0, plane_ff} + 4'd1 >= planes) &&
                                     (line_end >= {1'b0, height});
               col_in   = 11'd0;
               plane_in = plane_ff + 3'd1;
               if ({1'b0, plane_ff} + 4'd1 >= planes) begin
                  plane_in = 3'd0;
                  line_in  = line_end[14:0];
                  rep_in   = 8'd1;
               end
               done_in = data_in.image_done;
            end else begin
               col_in = col_end[10:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= 11'd0;
         plane_ff <= 3'd0;
         line_ff  <= 15'd0;
         rep_ff   <= 8'd1;
         valid_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         col_ff   <= col_in;
         plane_ff <= plane_in;
         line_ff  <= line_in;
         rep_ff   <= rep_in;
         valid_ff <= valid_in;
         done_ff  <= done_in;
      end
      data_ff <= data_in;
   end
endmodule

@@ rtl/bitplane_image_rle_depacker.sv @@
// bit-plane image run-length depacker: one packed byte per beat in, write descriptors out
// a descriptor passes the queue, then the output register; one byte accepted every cycle
// while the two-entry queue has room; throughput set by the front parser, one byte a cycle
// reset clears parse state, position, queue and output register; registers return to
// width 80, height 400, one plane, pattern length 2
module bitplane_image_rle_depacker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // stream_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,   // kind
   output logic         rsp_tlast,   // line_done
   // plane_index, line_index, column, run_length, data_low, data_high,
   // line_repeat, image_done, error_code, 4 zero bits
   output logic [183:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
`include "bitplane_image_rle_depacker_defines.svh"

   bird_pkg::cfg_type cfg_ff, cfg_in;
   bird_pkg::cmd_type push_data, pop_data;
   bird_pkg::rsp_type rsp;
   logic push, pop, full, empty, back_done, halted;
   logic wr;
   logic err_ok;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_paddr[3:2])
            bird_pkg::REG_LINE_WIDTH: cfg_in.width   = csr_pwdata[11:0];
            bird_pkg::REG_HEIGHT:     cfg_in.height  = csr_pwdata[14:0];
            bird_pkg::REG_PLANES:     cfg_in.planes  = csr_pwdata[3:0];
            bird_pkg::REG_PATTERN:    cfg_in.pattern = csr_pwdata[4:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         bird_pkg::REG_LINE_WIDTH: csr_prdata = {20'd0, cfg_ff.width};
         bird_pkg::REG_HEIGHT:     csr_prdata = {17'd0, cfg_ff.height};
         bird_pkg::REG_PLANES:     csr_prdata = {28'd0, cfg_ff.planes};
         bird_pkg::REG_PATTERN:    csr_prdata = {27'd0, cfg_ff.pattern};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{width: 12'd80, height: 15'd400, planes: 4'd1, pattern: 5'd2};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bird_front u_front (
      .clock, .reset, .cfg(cfg_ff),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_byte(req_tdata),
      .push, .push_data, .full, .back_done, .halted
   );

   bird_fifo u_fifo (
      .clock, .reset, .push, .push_data, .full, .empty, .pop, .pop_data
   );

   bird_back u_back (
      .clock, .reset, .cfg(cfg_ff), .empty, .pop, .pop_data,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp), .done(back_done)
   );

   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.line_done;
   assign rsp_tdata = {4'd0, rsp.error_code, rsp.image_done, rsp.line_repeat,
                       rsp.data_high, rsp.data_low, rsp.run_length,
                       rsp.column, rsp.line_index, rsp.plane_index};

   assign err_ok = (rsp.kind == bird_pkg::KIND_ERROR) ==
                   (rsp.error_code != bird_pkg::ERR_NONE);

   `BIRD_ASSERT(a_no_push_full, !(push && full), "push into full queue")
   `BIRD_ASSERT(a_err_code, !rsp_tvalid || err_ok, "error kind and code disagree")
   `BIRD_ASSERT_NEXT(a_halt_sticky, halted, halted, "halt cleared without reset")
endmodule

@@ dv/tb_bitplane_image_rle_depacker.sv @@
// self-checking testbench for the bit-plane image run-length depacker
// depends on bird_pkg and the top level bitplane_image_rle_depacker; a scoreboard
// class predicts write descriptors per accepted byte, plain tasks drive the ports
module tb_bitplane_image_rle_depacker;

   localparam int CYCLE_LIMIT = 400000;

   class depack_scoreboard;
      int width_reg, height_reg, planes_reg, pattern_reg;
      logic [2:0] phase;
      logic [7:0] pattern_bytes [16];
      int fill_idx, pat_count, lit_left;
      int col, plane, line, grp;
      bit halted;
      int mismatches;
      bird_pkg::rsp_type descriptors_due [$];

      function new();
         width_reg = 80; height_reg = 400; planes_reg = 1; pattern_reg = 2;
         phase = bird_pkg::PH_OPCODE; fill_idx = 0; pat_count = 0; lit_left = 0;
         col = 0; plane = 0; line = 0; grp = 1; halted = 0; mismatches = 0;
         foreach (pattern_bytes[i]) pattern_bytes[i] = '0;
      endfunction

      function void set_reg(logic [1:0] idx, int value);
         case (idx)
            bird_pkg::REG_LINE_WIDTH: width_reg = value & 'hFFF;
            bird_pkg::REG_HEIGHT:     height_reg = value & 'h7FFF;
            bird_pkg::REG_PLANES:     planes_reg = value & 'hF;
            bird_pkg::REG_PATTERN:    pattern_reg = value & 'h1F;
            default:                  pattern_reg = pattern_reg;
         endcase
      endfunction

      function int eff_width();
         if (width_reg == 0) return 1;
         return width_reg > bird_pkg::MAX_LINE_BYTES ? bird_pkg::MAX_LINE_BYTES : width_reg;
      endfunction
      function int eff_height();
         return height_reg == 0 ? 1 : height_reg;
      endfunction
      function int eff_planes();
         if (planes_reg == 0) return 1;
         return planes_reg > bird_pkg::MAX_PLANES ? bird_pkg::MAX_PLANES : planes_reg;
      endfunction
      function int eff_pattern();
         return pattern_reg > bird_pkg::MAX_PATTERN_BYTES ?
                bird_pkg::MAX_PATTERN_BYTES : pattern_reg;
      endfunction

      function void raise_error(logic [1:0] code);
         bird_pkg::rsp_type r;
         r = '0;
         r.kind = bird_pkg::KIND_ERROR;
         r.plane_index = plane[2:0];
         r.line_index = line[14:0];
         r.column = col[10:0];
         r.error_code = code;
         descriptors_due.push_back(r);
         halted = 1;
         phase = bird_pkg::PH_OPCODE;
      endfunction

      function void put_write(logic [1:0] k, int len, logic [63:0] lo, logic [63:0] hi);
         bird_pkg::rsp_type r;
         int w, h, rem, rep;
         bit ld, idn;
         w = eff_width();
         ld = 0; rep = 0; idn = 0;
         if (col + len > w) begin
            raise_error(bird_pkg::ERR_OVERRUN);
            return;
         end
         if (col + len == w) begin
            h = eff_height();
            rem = line < h ? h - line : 1;
            ld = 1;
            rep = grp < rem ? grp : rem;
            if (plane + 1 >= eff_planes() && line + rep >= h) idn = 1;
         end
         r = '0;
         r.kind = k;
         r.plane_index = plane[2:0];
         r.line_index = line[14:0];
         r.column = col[10:0];
         r.run_length = len[11:0];
         r.data_low = lo;
         r.data_high = hi;
         r.line_done = ld;
         r.line_repeat = rep[7:0];
         r.image_done = idn;
         r.error_code = bird_pkg::ERR_NONE;
         descriptors_due.push_back(r);
         col += len;
         if (ld) begin
            col = 0;
            plane++;
            if (plane >= eff_planes()) begin
               plane = 0;
               line = (line + rep) & 'h7FFF;
               grp = 1;
            end
            if (idn) halted = 1;
         end
      endfunction

      function void take_byte(logic [7:0] b);
         int plen;
         logic [63:0] lo, hi;
         plen = eff_pattern();
         if (halted) return;
         case (phase)
            bird_pkg::PH_OPCODE: begin
               if (b == 8'h00) phase = bird_pkg::PH_PAT_COUNT;
               else if (b == bird_pkg::OP_LITERAL) phase = bird_pkg::PH_LIT_COUNT;
               else put_write(bird_pkg::KIND_SOLID, int'(b & bird_pkg::RUN_MASK),
                              b[7] ? 64'hFF : 64'h0, '0);
            end
            bird_pkg::PH_PAT_COUNT: begin
               if (b == 8'h00) phase = bird_pkg::PH_SCAN_MARK;
               else if (plen == 0) phase = bird_pkg::PH_OPCODE;
               else if (col + int'(b) * plen > eff_width())
                  raise_error(bird_pkg::ERR_OVERRUN);
               else begin
                  pat_count = int'(b);
                  fill_idx = 0;
                  phase = bird_pkg::PH_PAT_BYTES;
               end
            end
            bird_pkg::PH_PAT_BYTES: begin
               pattern_bytes[fill_idx & 15] = b;
               fill_idx++;
               if (fill_idx >= plen) begin
                  lo = '0; hi = '0;
                  for (int i = 0; i < plen; i++) begin
                     if (i < 8) lo[8*i +: 8] = pattern_bytes[i];
                     else hi[8*(i-8) +: 8] = pattern_bytes[i];
                  end
                  fill_idx = 0;
                  phase = bird_pkg::PH_OPCODE;
                  put_write(bird_pkg::KIND_PATTERN, pat_count * plen, lo, hi);
               end
            end
            bird_pkg::PH_SCAN_MARK: begin
               if (b != bird_pkg::SCAN_MARKER) raise_error(bird_pkg::ERR_BAD_MARK);
               else phase = bird_pkg::PH_SCAN_COUNT;
            end
            bird_pkg::PH_SCAN_COUNT: begin
               grp = b == 8'h00 ? 1 : int'(b);
               phase = bird_pkg::PH_OPCODE;
            end
            bird_pkg::PH_LIT_COUNT: begin
               if (b == 8'h00) phase = bird_pkg::PH_OPCODE;
               else if (col + int'(b) > eff_width()) raise_error(bird_pkg::ERR_OVERRUN);
               else begin
                  lit_left = int'(b);
                  phase = bird_pkg::PH_LIT_BYTES;
               end
            end
            bird_pkg::PH_LIT_BYTES: begin
               if (lit_left <= 1) begin
                  lit_left = 0;
                  phase = bird_pkg::PH_OPCODE;
               end else lit_left--;
               put_write(bird_pkg::KIND_LITERAL, 1, {56'h0, b}, '0);
            end
            default: phase = bird_pkg::PH_OPCODE;
         endcase
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         mismatches++;
         $display("mismatch %s: got %0h expected %0h", what, got, want);
      endtask

      task cmp(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want) report(name, got, want);
      endtask

      task match_descriptor(logic [1:0] u, logic l, logic [183:0] d);
         bird_pkg::rsp_type e;
         if (descriptors_due.size() == 0) begin
            report("unexpected beat", d[63:0], '0);
            return;
         end
         e = descriptors_due.pop_front();
         cmp("kind", u, e.kind);
         cmp("plane_index", d[2:0], e.plane_index);
         cmp("line_index", d[17:3], e.line_index);
         cmp("column", d[28:18], e.column);
         cmp("run_length", d[40:29], e.run_length);
         cmp("data_low", d[104:41], e.data_low);
         cmp("data_high", d[168:105], e.data_high);
         cmp("line_done", l, e.line_done);
         cmp("line_repeat", d[176:169], e.line_repeat);
         cmp("image_done", d[177], e.image_done);
         cmp("error_code", d[179:178], e.error_code);
      endtask
   endclass

   logic         clock, reset;
   logic         req_tvalid, req_tready;
   logic [7:0]   req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic [183:0] rsp_tdata;
   logic         csr_psel, csr_penable, csr_pwrite;
   logic [3:0]   csr_paddr;
   logic [31:0]  csr_pwdata, csr_prdata;
   logic         csr_pready;

   depack_scoreboard sb;
   int  cycles = 0;
   int  sent = 0;
   bit  quiet = 0;
   bit  held = 0;

   bitplane_image_rle_depacker dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL bitplane_image_rle_depacker");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready)
         sb.match_descriptor(rsp_tuser, rsp_tlast, rsp_tdata);

   initial begin
      rsp_tready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!held && sent >= 300) begin
            held = 1;
            rsp_tready = 0;
            repeat (300) @(negedge clock);
         end
         if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_tready = 0;
            repeat ($urandom_range(1, 11)) @(negedge clock);
         end
         rsp_tready = 1;
      end
   end

   function automatic int imin(int a, int b);
      return a < b ? a : b;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid = 0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata = b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.take_byte(b);
      sent++;
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input int value);
      req_tvalid = 0;
      while (sb.descriptors_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_psel = 1; csr_pwrite = 1; csr_penable = 0;
      csr_paddr = {idx, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1;
      @(posedge clock);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0;
   endtask

   task automatic set_all(input int w, input int h, input int p, input int pl);
      csr_write(bird_pkg::REG_LINE_WIDTH, w);
      csr_write(bird_pkg::REG_HEIGHT, h);
      csr_write(bird_pkg::REG_PLANES, p);
      csr_write(bird_pkg::REG_PATTERN, pl);
   endtask

   task automatic send_solid(input int len);
      send_byte(($urandom_range(0, 1) ? 8'h80 : 8'h00) | len[7:0]);
   endtask

   task automatic finish_line();
      while (sb.col != 0 && !sb.halted)
         send_solid(imin(127, sb.eff_width() - sb.col));
   endtask

   task automatic random_op();
      int rem, sel, n, plen;
      rem = sb.eff_width() - sb.col;
      plen = sb.eff_pattern();
      sel = $urandom_range(0, 99);
      if (sel < 40) send_solid($urandom_range(1, imin(127, rem)));
      else if (sel < 60) begin
         n = $urandom_range(1, imin(8, imin(255, rem)));
         send_byte(bird_pkg::OP_LITERAL);
         send_byte(n[7:0]);
         repeat (n) send_byte(8'($urandom_range(0, 255)));
      end else if (sel < 80) begin
         if (plen == 0) begin
            send_byte(8'h00);
            send_byte(8'($urandom_range(1, 255)));
         end else if (rem / plen == 0) send_solid(imin(127, rem));
         else begin
            n = $urandom_range(1, imin(255, rem / plen));
            send_byte(8'h00);
            send_byte(n[7:0]);
            repeat (plen) send_byte(8'($urandom_range(0, 255)));
         end
      end else if (sel < 88) begin
         send_byte(8'h00); send_byte(8'h00); send_byte(bird_pkg::SCAN_MARKER);
         send_byte(8'($urandom_range(0, 3)));
      end else if (sel < 93) begin
         send_byte(bird_pkg::OP_LITERAL);
         send_byte(8'h00);
      end else send_solid(imin(127, rem));
   endtask

   initial begin
      int mode, rem;
      sb = new();
      reset = 1;
      req_tvalid = 0; req_tdata = '0;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset register values
      while (sent < 100) random_op();
      finish_line();

      // directed: run extremes, literals, full pattern, scan repeat cases
      set_all(300, 32767, 2, 16);
      send_byte(8'h01); send_byte(8'h81); send_byte(8'h7F); send_byte(8'hFF);
      send_byte(bird_pkg::OP_LITERAL); send_byte(8'h03);
      send_byte(8'h00); send_byte(8'hFF); send_byte(8'h5A);
      send_byte(8'h00); send_byte(8'h01);
      for (int i = 0; i < 16; i++) send_byte(8'(8'h11 * i));
      send_byte(8'h00); send_byte(8'h00); send_byte(bird_pkg::SCAN_MARKER);
      send_byte(8'h00);
      send_byte(8'h00); send_byte(8'h00); send_byte(bird_pkg::SCAN_MARKER);
      send_byte(8'hFF);
      send_byte(bird_pkg::OP_LITERAL); send_byte(8'h00);
      finish_line();

      set_all(1, 32767, 8, 16);
      while (sent < 250) random_op();
      finish_line();
      set_all(2048, 32767, 1, 0);
      while (sent < 400) random_op();
      finish_line();
      set_all(0, 32767, 15, 31);
      while (sent < 500) random_op();
      finish_line();
      while (sent < 1750) begin
         set_all($urandom_range(1, 64), 32767, $urandom_range(1, 8), $urandom_range(0, 16));
         repeat (60) random_op();
         finish_line();
      end

      quiet = 1;
      set_all(16, 32767, 1, 4);
      while (sent < 1850) random_op();
      finish_line();
      mode = $urandom_range(0, 2);
      if (mode == 0) begin
         csr_write(bird_pkg::REG_HEIGHT, 1);
         while (!sb.halted) random_op();
      end else if (mode == 1) begin
         send_byte(8'h00); send_byte(8'h00); send_byte(8'h5A);
      end else begin
         send_solid(5);
         rem = sb.eff_width() - sb.col;
         send_solid(rem + 1);
      end
      repeat (20) send_byte(8'($urandom_range(0, 255)));
      req_tvalid = 0;

      while (sb.descriptors_due.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (sb.mismatches == 0)
         $display("PASS bitplane_image_rle_depacker");
      else
         $display("FAIL bitplane_image_rle_depacker");
      $finish;
   end
endmodule
